/* hw/rtl/haar_feature_evaluator_core_defines.svh */
// Assertion macros used by the port checker of the Haar feature evaluator.
// Each macro takes a label, the clock, the active-low reset, a condition and
// a property that must follow from it.
`ifndef HAAR_FEATURE_EVALUATOR_CORE_DEFINES_SVH
`define HAAR_FEATURE_EVALUATOR_CORE_DEFINES_SVH

// The property must hold in the same cycle as the condition.
`define HFE_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("hfe check failed");

// The property must hold in the cycle after the condition.
`define HFE_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("hfe check failed");

// The property must hold after the condition, later than HFE_ASSERT_NEXT checks.
`define HFE_ASSERT_TWO(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> ##2 (prop)) \
        else $error("hfe check failed");

`endif

/* hw/rtl/hfe_pkg.sv */
// ----------------------------------------------------------------------------
// Haar feature evaluator package
// Types, codes and fixed widths shared by the controller, datapath and checker.
// ----------------------------------------------------------------------------
package hfe_pkg;

    // Fixed field widths.
    localparam int MODE_W   = 3;
    localparam int COORD_W  = 5;
    localparam int VALUE_W  = 24;
    localparam int RESULT_W = 27;
    localparam int ACC_W    = 32;

    // Reciprocal of three for small widths: floor(x / 3) == (x * 171) >> 9.
    localparam int RECIP3_MUL = 171;
    localparam int RECIP3_W   = 8;
    localparam int RECIP3_SH  = 9;

    // Saturation bounds of the result, held at accumulator width.
    localparam logic signed [ACC_W-1:0] ACC_RES_MAX =
        ACC_W'((64'sd1 <<< (RESULT_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] ACC_RES_MIN = -ACC_RES_MAX - ACC_W'(1);

    // Request codes.
    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD       = 3'd0,
        MODE_RECT       = 3'd1,
        MODE_ROW_HALVES = 3'd2,
        MODE_COL_HALVES = 3'd3,
        MODE_COL_THIRDS = 3'd4,
        MODE_QUADS      = 3'd5
    } t_mode;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    // Corner weight along one axis: sign and a factor of two.
    typedef struct packed {
        logic neg;
        logic dbl;
    } t_wt;

    localparam t_wt W_POS  = '{neg: 1'b0, dbl: 1'b0};
    localparam t_wt W_NEG  = '{neg: 1'b1, dbl: 1'b0};
    localparam t_wt W_POS2 = '{neg: 1'b0, dbl: 1'b1};
    localparam t_wt W_NEG2 = '{neg: 1'b1, dbl: 1'b1};

    // Controller to datapath.
    typedef struct packed {
        logic       accept;
        logic       issue;
        logic       out_load;
        logic [1:0] row_sel;
        logic [1:0] col_sel;
    } t_hfe_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic       is_load;
        logic       is_bad;
        logic [1:0] row_max;
        logic [1:0] col_max;
    } t_hfe_status;

endpackage

/* hw/rtl/hfe_datapath.sv */
// ----------------------------------------------------------------------------
// Haar feature evaluator datapath
// Integral store, corner table, address generation, weighted accumulator,
// saturation and the output register.
// ----------------------------------------------------------------------------
module hfe_datapath
    import hfe_pkg::*;
#(
    parameter int WINDOW_ROWS = 24,
    parameter int WINDOW_COLS = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_hfe_cmd                   i_cmd,
    output t_hfe_status                o_status,
    input  logic [MODE_W-1:0]          i_mode,
    input  logic [COORD_W-1:0]         i_row_top,
    input  logic [COORD_W-1:0]         i_col_left,
    input  logic [COORD_W-1:0]         i_row_bottom,
    input  logic [COORD_W-1:0]         i_col_right,
    input  logic [VALUE_W-1:0]         i_load_value,
    output logic signed [RESULT_W-1:0] o_feature_value,
    output logic                       o_bad_request
);

    // Corner points are kept one above their index, so zero means "row -1"
    // or "column -1", which reads as zero.
    localparam int RW    = $clog2(WINDOW_ROWS + 1);
    localparam int CW    = $clog2(WINDOW_COLS + 1);
    localparam int RI    = $clog2(WINDOW_ROWS);
    localparam int CI    = $clog2(WINDOW_COLS);
    localparam int DEPTH = WINDOW_ROWS * WINDOW_COLS;
    localparam int AW    = $clog2(DEPTH);

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] r_rd_data;

    logic [RW-1:0] r_row_pt [3];
    logic [RW-1:0] n_row_pt [3];
    t_wt           r_row_wt [3];
    t_wt           n_row_wt [3];
    logic [CW-1:0] r_col_pt [4];
    logic [CW-1:0] n_col_pt [4];
    t_wt           r_col_wt [4];
    t_wt           n_col_wt [4];
    logic [1:0]    r_row_max, n_row_max;
    logic [1:0]    r_col_max, n_col_max;
    logic          r_bad;

    logic [RW-1:0]          top_r, bot_r, half_r;
    logic [CW-1:0]          lft_c, rgt_c, half_c, wid_c, third_c;
    logic [CW+RECIP3_W-1:0] wid_prod;
    logic                   in_bad, load_ok;

    logic [RW-1:0]  sel_rp;
    logic [CW-1:0]  sel_cp;
    logic [RI-1:0]  rd_row;
    logic [CI-1:0]  rd_col;
    logic           rd_zero;
    logic [AW-1:0]  rd_addr, wr_addr, mem_addr;
    logic           wr_en;

    logic                      r_p_valid;
    logic                      r_p_zero;
    logic                      r_p_neg;
    logic [1:0]                r_p_shift;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   term;
    logic signed [ACC_W-1:0]   sat;

    logic signed [RESULT_W-1:0] r_out_value;
    logic                       r_out_bad;

    // Request checks on the incoming word.
    always_comb begin
        in_bad = (i_mode > MODE_QUADS)
              || (i_row_top > i_row_bottom)
              || (i_col_left > i_col_right)
              || (int'(i_row_bottom) >= WINDOW_ROWS)
              || (int'(i_col_right) >= WINDOW_COLS);
        load_ok = (int'(i_row_top) < WINDOW_ROWS) && (int'(i_col_left) < WINDOW_COLS);
    end

    assign o_status.is_load = (i_mode == MODE_LOAD);
    assign o_status.is_bad  = in_bad;
    assign o_status.row_max = r_row_max;
    assign o_status.col_max = r_col_max;

    // Split sizes of the requested rectangle.
    always_comb begin
        top_r    = RW'(i_row_top);
        bot_r    = RW'(i_row_bottom);
        lft_c    = CW'(i_col_left);
        rgt_c    = CW'(i_col_right);
        half_r   = (bot_r - top_r) >> 1;
        half_c   = (rgt_c - lft_c) >> 1;
        wid_c    = rgt_c - lft_c + CW'(1);
        wid_prod = (CW + RECIP3_W)'(wid_c) * (CW + RECIP3_W)'(RECIP3_MUL);
        third_c  = CW'(wid_prod >> RECIP3_SH);
    end

    // Corner table: every feature is a product of a row weighting and a
    // column weighting over a few boundary lines.
    always_comb begin
        n_row_pt[0] = top_r;
        n_row_pt[1] = bot_r + RW'(1);
        n_row_pt[2] = bot_r + RW'(1);
        n_row_wt[0] = W_NEG;
        n_row_wt[1] = W_POS;
        n_row_wt[2] = W_POS;
        n_row_max   = 2'd1;
        n_col_pt[0] = lft_c;
        n_col_pt[1] = rgt_c + CW'(1);
        n_col_pt[2] = rgt_c + CW'(1);
        n_col_pt[3] = rgt_c + CW'(1);
        n_col_wt[0] = W_NEG;
        n_col_wt[1] = W_POS;
        n_col_wt[2] = W_POS;
        n_col_wt[3] = W_POS;
        n_col_max   = 2'd1;
        case (t_mode'(i_mode))
            MODE_ROW_HALVES: begin
                n_row_pt[1] = top_r + half_r + RW'(1);
                n_row_wt[1] = W_POS2;
                n_row_wt[2] = W_NEG;
                n_row_max   = 2'd2;
            end
            MODE_COL_HALVES: begin
                n_col_pt[1] = lft_c + half_c + CW'(1);
                n_col_wt[0] = W_POS;
                n_col_wt[1] = W_NEG2;
                n_col_wt[2] = W_POS;
                n_col_max   = 2'd2;
            end
            MODE_COL_THIRDS: begin
                n_col_pt[1] = lft_c + third_c;
                n_col_pt[2] = lft_c + third_c + third_c;
                n_col_wt[0] = W_POS;
                n_col_wt[1] = W_NEG2;
                n_col_wt[2] = W_POS2;
                n_col_wt[3] = W_NEG;
                n_col_max   = 2'd3;
            end
            MODE_QUADS: begin
                n_row_pt[1] = top_r + half_r + RW'(1);
                n_row_wt[1] = W_POS2;
                n_row_wt[2] = W_NEG;
                n_row_max   = 2'd2;
                n_col_pt[1] = lft_c + half_c + CW'(1);
                n_col_wt[0] = W_POS;
                n_col_wt[1] = W_NEG2;
                n_col_wt[2] = W_POS;
                n_col_max   = 2'd2;
            end
            default: begin
                n_row_max = 2'd1;
            end
        endcase
    end

    // Capture the corner table and the request flag on acceptance.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_row_pt  <= n_row_pt;
            r_row_wt  <= n_row_wt;
            r_col_pt  <= n_col_pt;
            r_col_wt  <= n_col_wt;
            r_row_max <= n_row_max;
            r_col_max <= n_col_max;
            r_bad     <= in_bad;
        end
    end

    // Address of the selected corner; a corner on row or column -1 is skipped.
    always_comb begin
        sel_rp  = r_row_pt[i_cmd.row_sel];
        sel_cp  = r_col_pt[i_cmd.col_sel];
        rd_zero = (sel_rp == '0) || (sel_cp == '0);
        rd_row  = RI'(sel_rp - RW'(1));
        rd_col  = CI'(sel_cp - CW'(1));
        rd_addr = rd_zero ? '0 : AW'(int'(rd_row) * WINDOW_COLS + int'(rd_col));
        wr_addr = AW'(int'(i_row_top) * WINDOW_COLS + int'(i_col_left));
        wr_en   = i_cmd.accept && (i_mode == MODE_LOAD) && load_ok;
        mem_addr = wr_en ? wr_addr : rd_addr;
    end

    // Single-port integral store with registered read data.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[mem_addr] <= i_load_value;
        end else begin
            r_rd_data <= mem[mem_addr];
        end
    end

    // Weight of the corner in flight travels alongside the read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_zero  <= rd_zero;
        r_p_neg   <= r_row_wt[i_cmd.row_sel].neg ^ r_col_wt[i_cmd.col_sel].neg;
        r_p_shift <= {1'b0, r_row_wt[i_cmd.row_sel].dbl}
                   + {1'b0, r_col_wt[i_cmd.col_sel].dbl};
    end

    // Accumulate the weighted corner value.
    assign term = signed'(ACC_W'(r_rd_data) << r_p_shift);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_acc <= '0;
        end else if (r_p_valid && !r_p_zero) begin
            r_acc <= r_p_neg ? (r_acc - term) : (r_acc + term);
        end
    end

    // Clamp to the signed result range.
    always_comb begin
        if (r_acc > ACC_RES_MAX) begin
            sat = ACC_RES_MAX;
        end else if (r_acc < ACC_RES_MIN) begin
            sat = ACC_RES_MIN;
        end else begin
            sat = r_acc;
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value <= r_bad ? '0 : RESULT_W'(sat);
            r_out_bad   <= r_bad;
        end
    end

    assign o_feature_value = r_out_value;
    assign o_bad_request   = r_out_bad;

endmodule

/* hw/rtl/hfe_ctrl.sv */
// ----------------------------------------------------------------------------
// Haar feature evaluator controller
// Handshakes, corner sequencing over the single-port store, output valid.
// ----------------------------------------------------------------------------
module hfe_ctrl
    import hfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    input  t_hfe_status i_status,
    output t_hfe_cmd    o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_row_sel, n_row_sel;
    logic [1:0] r_col_sel, n_col_sel;
    logic       r_out_valid, n_out_valid;

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_sel   <= 2'd0;
            r_col_sel   <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_sel   <= n_row_sel;
            r_col_sel   <= n_col_sel;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state        = r_state;
        n_row_sel      = r_row_sel;
        n_col_sel      = r_col_sel;
        o_in_ready     = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.issue    = 1'b0;
        o_cmd.out_load = 1'b0;
        o_cmd.row_sel  = r_row_sel;
        o_cmd.col_sel  = r_col_sel;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_row_sel    = 2'd0;
                    n_col_sel    = 2'd0;
                    if (i_status.is_load) begin
                        n_state = S_IDLE;
                    end else if (i_status.is_bad) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (r_col_sel == i_status.col_max) begin
                    n_col_sel = 2'd0;
                    if (r_row_sel == i_status.row_max) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_row_sel = r_row_sel + 2'd1;
                    end
                end else begin
                    n_col_sel = r_col_sel + 2'd1;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when the word is taken.
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* hw/rtl/haar_feature_evaluator_core.sv */
// Sequence: a query is accepted in S_IDLE, its N corners are read in S_RUN
// (4 rectangle sum, 6 halves, 8 thirds, 9 quadrants), the last read is summed
// in S_DRAIN and its word is loaded in S_DONE once the output is free; a
// flagged request goes straight to S_DONE, and a load gives no word. The input
// stays closed until that word is loaded; loads are taken one per cycle. The
// single-port store is read one corner a cycle. Reset is synchronous, active low, clears control state only.
// ----------------------------------------------------------------------------
// Haar feature evaluator core
// Integral-image store of one detection window with rectangle-sum and
// Haar feature queries, built as a controller and a datapath.
// ----------------------------------------------------------------------------
module haar_feature_evaluator_core
    import hfe_pkg::*;
#(
    parameter int WINDOW_COLS = 24,
    parameter int WINDOW_ROWS = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [MODE_W-1:0]          i_mode,
    input  logic [COORD_W-1:0]         i_row_top,
    input  logic [COORD_W-1:0]         i_col_left,
    input  logic [COORD_W-1:0]         i_row_bottom,
    input  logic [COORD_W-1:0]         i_col_right,
    input  logic [VALUE_W-1:0]         i_load_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [RESULT_W-1:0] o_feature_value,
    output logic                       o_bad_request
);

    t_hfe_cmd    cmd;
    t_hfe_status status;

    // Sequencing and handshakes.
    hfe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Store, corner arithmetic and output word.
    hfe_datapath #(
        .WINDOW_ROWS (WINDOW_ROWS),
        .WINDOW_COLS (WINDOW_COLS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_mode          (i_mode),
        .i_row_top       (i_row_top),
        .i_col_left      (i_col_left),
        .i_row_bottom    (i_row_bottom),
        .i_col_right     (i_col_right),
        .i_load_value    (i_load_value),
        .o_feature_value (o_feature_value),
        .o_bad_request   (o_bad_request)
    );

endmodule

/* hw/rtl/hfe_checker.sv */
// ----------------------------------------------------------------------------
// Haar feature evaluator port checker
// Watches held outputs, flagged words, silent loads, unused modes and busy input.
// ----------------------------------------------------------------------------
`include "haar_feature_evaluator_core_defines.svh"

module hfe_checker
    import hfe_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic [MODE_W-1:0]          i_mode,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic signed [RESULT_W-1:0] o_feature_value,
    input logic                       o_bad_request
);

    logic in_acc;

    assign in_acc = i_in_valid && o_in_ready;

    // A stalled result word holds.
    `HFE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_feature_value) && $stable(o_bad_request))

    // A flagged word always carries zero.
    `HFE_ASSERT_SAME(a_bad_zero, i_clk, i_rst_n, o_out_valid && o_bad_request, o_feature_value == '0)

    // A load never produces a word.
    `HFE_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, in_acc && !o_out_valid && (i_mode == MODE_LOAD), !o_out_valid)

    // An unused mode, when the output is free, is flagged via S_DONE and the output word register.
    `HFE_ASSERT_TWO(a_bad_mode, i_clk, i_rst_n, in_acc && !o_out_valid && (i_mode > MODE_QUADS), o_out_valid && o_bad_request)

    // A query keeps the input side closed while it is in progress.
    `HFE_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, in_acc && (i_mode != MODE_LOAD), !o_in_ready)

endmodule

bind haar_feature_evaluator_core hfe_checker u_hfe_checker (.*);

/* bench/haar_feature_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Haar feature evaluator checker
// Watches both channels of the evaluator core. It keeps its own copy of the
// integral image and works out the feature word for each accepted query, then
// compares every accepted output word with the oldest outstanding one.
// ----------------------------------------------------------------------------
module haar_feature_checker
    import hfe_pkg::*;
#(
    parameter int WINDOW_COLS = 24,
    parameter int WINDOW_ROWS = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [MODE_W-1:0]          i_mode,
    input  logic [COORD_W-1:0]         i_row_top,
    input  logic [COORD_W-1:0]         i_col_left,
    input  logic [COORD_W-1:0]         i_row_bottom,
    input  logic [COORD_W-1:0]         i_col_right,
    input  logic [VALUE_W-1:0]         i_load_value,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic signed [RESULT_W-1:0] i_feature_value,
    input  logic                       i_bad_request,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam int HALF_DIV  = 2;
    localparam int THIRD_DIV = 3;
    localparam longint FEATURE_MAX = (64'sd1 <<< (RESULT_W - 1)) - 64'sd1;
    localparam longint FEATURE_MIN = -FEATURE_MAX - 64'sd1;

    typedef struct packed {
        logic signed [RESULT_W-1:0] value;
        logic                       bad;
    } t_feature_word;

    logic [VALUE_W-1:0] integral_copy [WINDOW_ROWS*WINDOW_COLS];
    t_feature_word      pending_features [$];
    int                 fail_total = 0;

    // A corner above row 0 or left of column 0 reads as zero.
    function automatic longint corner_at(input int r, input int c);
        if (r < 0 || c < 0 || r >= WINDOW_ROWS || c >= WINDOW_COLS) begin
            return 0;
        end
        return longint'(integral_copy[r*WINDOW_COLS + c]);
    endfunction

    // Inclusive rectangle sum from the four integral corners.
    function automatic longint box_sum(input int r0, input int c0, input int r1, input int c1);
        return corner_at(r1, c1) - corner_at(r0 - 1, c1)
             - corner_at(r1, c0 - 1) + corner_at(r0 - 1, c0 - 1);
    endfunction

    // Feature word for one query, saturated to the signed result width.
    function automatic t_feature_word predict_feature(input logic [MODE_W-1:0] mode,
                                                      input int t, input int l,
                                                      input int b, input int r);
        t_feature_word w;
        longint        v;
        int            dr;
        int            dc;
        int            d3;
        v     = 0;
        w.bad = 1'b0;
        dr    = (b - t) / HALF_DIV;
        dc    = (r - l) / HALF_DIV;
        d3    = (r - l + 1) / THIRD_DIV;
        if (t > b || l > r || b >= WINDOW_ROWS || r >= WINDOW_COLS) begin
            w.bad = 1'b1;
        end else begin
            case (mode)
                MODE_RECT: begin
                    v = box_sum(t, l, b, r);
                end
                MODE_ROW_HALVES: begin
                    v = box_sum(t, l, t + dr, r) - box_sum(t + dr + 1, l, b, r);
                end
                MODE_COL_HALVES: begin
                    v = box_sum(t, l + dc + 1, b, r) - box_sum(t, l, b, l + dc);
                end
                MODE_COL_THIRDS: begin
                    v = -box_sum(t, l, b, l + d3 - 1)
                        + box_sum(t, l + d3, b, l + 2*d3 - 1)
                        - box_sum(t, l + 2*d3, b, r);
                end
                MODE_QUADS: begin
                    v = -box_sum(t, l, t + dr, l + dc)
                        + box_sum(t, l + dc + 1, t + dr, r)
                        + box_sum(t + dr + 1, l, b, l + dc)
                        - box_sum(t + dr + 1, l + dc + 1, b, r);
                end
                default: begin
                    // The spare codes are rejected.
                    w.bad = 1'b1;
                end
            endcase
        end
        if (v > FEATURE_MAX) begin
            v = FEATURE_MAX;
        end
        if (v < FEATURE_MIN) begin
            v = FEATURE_MIN;
        end
        w.value = RESULT_W'(v);
        return w;
    endfunction

    // Only the first few failures are printed; the rest are counted.
    task automatic log_failure(input string what);
        fail_total++;
        if (fail_total <= 10) begin
            $display("%0t ns: %s", $time, what);
        end
    endtask

    // Both channels are sampled at the clock edge, before the block updates.
    always @(posedge i_clk) begin
        t_feature_word expected;
        if (!i_rst_n) begin
            pending_features.delete();
        end else begin
            // Output side: compare with the oldest outstanding word.
            if (i_out_valid && i_out_ready) begin
                if (pending_features.size() == 0) begin
                    log_failure($sformatf("unexpected word: value %0d bad %0b",
                                          i_feature_value, i_bad_request));
                end else begin
                    expected = pending_features.pop_front();
                    if (expected.value !== i_feature_value ||
                        expected.bad !== i_bad_request) begin
                        log_failure($sformatf(
                            "word mismatch: expected value %0d bad %0b, got value %0d bad %0b",
                            expected.value, expected.bad, i_feature_value, i_bad_request));
                    end
                end
            end
            // Input side: a load updates the image copy, a query adds a word.
            if (i_in_valid && i_in_ready) begin
                if (i_mode == MODE_LOAD) begin
                    if (int'(i_row_top) < WINDOW_ROWS && int'(i_col_left) < WINDOW_COLS) begin
                        integral_copy[int'(i_row_top)*WINDOW_COLS + int'(i_col_left)] =
                            i_load_value;
                    end
                end else begin
                    pending_features.push_back(predict_feature(i_mode, int'(i_row_top),
                                                               int'(i_col_left),
                                                               int'(i_row_bottom),
                                                               int'(i_col_right)));
                end
            end
        end
        o_pending    <= pending_features.size();
        o_fail_count <= fail_total;
    end

endmodule

/* bench/tb_haar_feature_evaluator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Haar feature evaluator core testbench
// Fills the integral image, runs directed corner cases of every feature type
// and rejected request, then a random mix of loads, queries and malformed
// words with random idle cycles on both channels. The checker beside the
// block predicts and compares every output word.
// ----------------------------------------------------------------------------
module tb_haar_feature_evaluator_core;
    import hfe_pkg::*;

    localparam int ROWS = 24;
    localparam int COLS = 24;
    localparam int RANDOM_WORDS = 400;
    localparam int COORD_MAX = (1 << COORD_W) - 1;
    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic [MODE_W-1:0]          i_mode;
    logic [COORD_W-1:0]         i_row_top;
    logic [COORD_W-1:0]         i_col_left;
    logic [COORD_W-1:0]         i_row_bottom;
    logic [COORD_W-1:0]         i_col_right;
    logic [VALUE_W-1:0]         i_load_value;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic signed [RESULT_W-1:0] o_feature_value;
    logic                       o_bad_request;
    int                         fail_count;
    int                         words_pending;
    bit                         no_idle = 1'b0;

    // Clock: 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    haar_feature_evaluator_core #(
        .WINDOW_COLS(COLS),
        .WINDOW_ROWS(ROWS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_row_top      (i_row_top),
        .i_col_left     (i_col_left),
        .i_row_bottom   (i_row_bottom),
        .i_col_right    (i_col_right),
        .i_load_value   (i_load_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_feature_value(o_feature_value),
        .o_bad_request  (o_bad_request)
    );

    haar_feature_checker #(
        .WINDOW_COLS(COLS),
        .WINDOW_ROWS(ROWS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_row_top      (i_row_top),
        .i_col_left     (i_col_left),
        .i_row_bottom   (i_row_bottom),
        .i_col_right    (i_col_right),
        .i_load_value   (i_load_value),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_feature_value(o_feature_value),
        .i_bad_request  (o_bad_request),
        .o_fail_count   (fail_count),
        .o_pending      (words_pending)
    );

    // Idle cycles before a word; none while a burst stretch is running.
    function automatic int draw_wait();
        if (no_idle) begin
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    // Present one input word after a random gap and hold it until accepted.
    task automatic send_word(input logic [MODE_W-1:0] mode,
                             input int t, input int l,
                             input int b, input int r,
                             input logic [VALUE_W-1:0] val);
        int gap;
        gap = draw_wait();
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_row_top    <= COORD_W'(t);
        i_col_left   <= COORD_W'(l);
        i_row_bottom <= COORD_W'(b);
        i_col_right  <= COORD_W'(r);
        i_load_value <= val;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Output side: random stall after each accepted word.
    initial begin
        int stall;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_wait();
            repeat (stall) begin
                i_out_ready <= 1'b0;
                @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Run limit.
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        logic [VALUE_W-1:0]  val;
        int                  t;
        int                  l;
        int                  b;
        int                  r;
        int                  kind;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_mode       <= MODE_LOAD;
        i_row_top    <= '0;
        i_col_left   <= '0;
        i_row_bottom <= '0;
        i_col_right  <= '0;
        i_load_value <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill every entry. Two 3x3 patches near the top are set so that a
        // quadrant query over each one drives the result past either bound.
        for (int row = 0; row < ROWS; row++) begin
            for (int col = 0; col < COLS; col++) begin
                if (row <= 2 && col <= 2) begin
                    val = ((row + col) % 2 == 1) ? VALUE_MAX : '0;
                end else if (row <= 2 && col >= 4 && col <= 6) begin
                    val = ((row + col - 4) % 2 == 1) ? '0 : VALUE_MAX;
                end else begin
                    val = VALUE_W'($urandom_range(0, VALUE_MAX));
                end
                send_word(MODE_LOAD, row, col, $urandom_range(0, COORD_MAX),
                          $urandom_range(0, COORD_MAX), val);
            end
        end

        // Directed queries: window extremes, narrow splits, saturation and
        // every kind of rejected request.
        send_word(MODE_RECT, 0, 0, ROWS - 1, COLS - 1, '0);
        send_word(MODE_RECT, 0, 0, 0, 0, '0);
        send_word(MODE_RECT, ROWS - 1, COLS - 1, ROWS - 1, COLS - 1, '0);
        send_word(MODE_ROW_HALVES, 5, 2, 5, 9, '0);
        send_word(MODE_ROW_HALVES, 3, 4, 9, 12, '0);
        send_word(MODE_COL_HALVES, 2, 7, 20, 7, '0);
        send_word(MODE_COL_HALVES, 0, 0, ROWS - 1, COLS - 1, '0);
        send_word(MODE_COL_THIRDS, 4, 10, 8, 10, '0);
        send_word(MODE_COL_THIRDS, 4, 10, 8, 11, '0);
        send_word(MODE_COL_THIRDS, 4, 10, 8, 12, '0);
        send_word(MODE_COL_THIRDS, 0, 0, ROWS - 1, COLS - 2, '0);
        send_word(MODE_QUADS, 0, 0, ROWS - 1, COLS - 1, '0);
        send_word(MODE_QUADS, 1, 1, 2, 2, '0);
        send_word(MODE_QUADS, 1, 5, 2, 6, '0);
        send_word(MODE_QUADS, 7, 3, 7, 15, '0);
        send_word(MODE_RECT, 10, 3, 9, 6, '0);
        send_word(MODE_COL_HALVES, 3, 12, 6, 11, '0);
        send_word(MODE_ROW_HALVES, 0, 0, ROWS, 5, '0);
        send_word(MODE_QUADS, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, VALUE_MAX);
        send_word(MODE_SPARE_6, 1, 1, 4, 4, '0);
        send_word(MODE_SPARE_7, 0, 0, ROWS - 1, COLS - 1, '0);
        send_word(MODE_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, VALUE_MAX);
        send_word(MODE_LOAD, ROWS, 0, 0, 0, '0);
        send_word(MODE_RECT, 0, 0, ROWS - 1, COLS - 1, '0);

        // Random mix: mostly well-formed queries and in-window loads, plus
        // loads anywhere and random-coordinate queries with any non-load code.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if ($urandom_range(0, 49) == 0) begin
                no_idle = !no_idle;
            end
            kind = $urandom_range(0, 99);
            case ($urandom_range(0, 7))
                0:       val = '0;
                1:       val = VALUE_MAX;
                default: val = VALUE_W'($urandom_range(0, VALUE_MAX));
            endcase
            if (kind < 25) begin
                send_word(MODE_LOAD, $urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1),
                          $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), val);
            end else if (kind < 30) begin
                send_word(MODE_LOAD, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                          $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), val);
            end else if (kind < 90) begin
                t = $urandom_range(0, ROWS - 1);
                l = $urandom_range(0, COLS - 1);
                if ($urandom_range(0, 3) == 0) begin
                    b = (t + $urandom_range(0, 3) > ROWS - 1) ? ROWS - 1 :
                        t + $urandom_range(0, 3);
                end else begin
                    b = $urandom_range(t, ROWS - 1);
                end
                if ($urandom_range(0, 3) == 0) begin
                    r = (l + $urandom_range(0, 3) > COLS - 1) ? COLS - 1 :
                        l + $urandom_range(0, 3);
                end else begin
                    r = $urandom_range(l, COLS - 1);
                end
                send_word(MODE_W'($urandom_range(MODE_RECT, MODE_QUADS)), t, l, b, r, val);
            end else begin
                send_word(MODE_W'($urandom_range(MODE_RECT, MODE_SPARE_7)),
                          $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                          $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), val);
            end
        end
        i_in_valid <= 1'b0;

        // Drain outstanding words, then allow a few more cycles for strays.
        @(posedge i_clk);
        while (words_pending != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/hfe_pkg.sv
hw/rtl/hfe_datapath.sv
hw/rtl/hfe_ctrl.sv
hw/rtl/haar_feature_evaluator_core.sv
hw/rtl/hfe_checker.sv
bench/haar_feature_checker.sv
bench/tb_haar_feature_evaluator_core.sv
